@@ hw/rtl/cdc_pkg.sv @@
// Package for the calendar date converter: word types, mode codes, calendar constants,
// reciprocal constants for the constant divisions and small month tables.
// No dependencies.
package cdc_pkg;

  typedef enum logic [2:0] {
    MODE_G2J = 3'd0,
    MODE_J2G = 3'd1,
    MODE_P2J = 3'd2,
    MODE_J2P = 3'd3,
    MODE_G2P = 3'd4,
    MODE_P2G = 3'd5
  } conv_mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [22:0] day_number_in;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
  } in_word_t;

  typedef struct packed {
    logic [22:0] day_number_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic        range_error;
  } out_word_t;

  // what travels beside the conversion pipes
  typedef struct packed {
    logic [2:0]  mode;
    logic        err;
    logic [22:0] jdn;
  } side_t;

  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned CONV_STAGES  = 10;
  localparam int unsigned N_STAGES     = FRONT_STAGES + CONV_STAGES + 1;

  localparam logic [22:0] JDN_LOW      = 23'd1721426;
  localparam logic [22:0] JDN_HIGH     = 23'd5373484;
  localparam logic [14:0] YEAR_MAX     = 15'd9999;
  localparam logic [22:0] PERS_JDN_475 = 23'd2121446;
  localparam logic [19:0] CYCLE_DAYS   = 20'd1029983;
  localparam logic [11:0] CYCLE_YEARS  = 12'd2820;
  localparam int          CYCLE_YDIV   = 1028522;
  localparam logic [25:0] GREG_OFS     = 26'd32075;
  localparam logic [22:0] GJ_OFS       = 23'd68569;

  // floor(x/D) == (x*M) >> K when x*D <= 2**K, M = ceil(2**K / D)
  localparam int KN   = 43;
  localparam longint unsigned MN   = ((64'd1 << KN) + 64'd146096) / 64'd146097;
  localparam int KI   = 49;
  localparam longint unsigned MI   = ((64'd1 << KI) + 64'd1461000) / 64'd1461001;
  localparam int KJ   = 28;
  localparam longint unsigned MJ   = ((64'd1 << KJ) + 64'd2446) / 64'd2447;
  localparam int K80  = 22;
  localparam longint unsigned M80  = ((64'd1 << K80) + 64'd79) / 64'd80;
  localparam int K183 = 27;
  localparam longint unsigned M183 = ((64'd1 << K183) + 64'd182) / 64'd183;
  localparam int K11  = 18;
  localparam longint unsigned M11  = ((64'd1 << K11) + 64'd10) / 64'd11;
  localparam int K100 = 21;
  localparam longint unsigned M100 = ((64'd1 << K100) + 64'd99) / 64'd100;

  // floor(367*(m-2-12a)/12) of the Gregorian formula
  function automatic logic [8:0] greg_mterm(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // days of the Persian year before month m
  function automatic logic [8:0] pers_mdays(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd62;
      4'd4:    r = 9'd93;
      4'd5:    r = 9'd124;
      4'd6:    r = 9'd155;
      4'd7:    r = 9'd186;
      4'd8:    r = 9'd216;
      4'd9:    r = 9'd246;
      4'd10:   r = 9'd276;
      4'd11:   r = 9'd306;
      4'd12:   r = 9'd336;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // epoch - 1 + cycle * cycle length, cycle index -1..3 coded 0..4
  function automatic logic [22:0] pers_cyc_ofs(input logic [2:0] q);
    logic [22:0] r;
    case (q)
      3'd0:    r = 23'd918337;
      3'd1:    r = 23'd1948320;
      3'd2:    r = 23'd2978303;
      3'd3:    r = 23'd4008286;
      default: r = 23'd5038269;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/cdc_p2j.sv @@
// Persian date to day number, three register stages.
// Depends on cdc_pkg.
module cdc_p2j
  import cdc_pkg::*;
(
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [13:0] year,
  input  logic [8:0]  mdays,
  input  logic [4:0]  day,
  output logic [23:0] jdn
);

  logic [2:0]  qidx;
  logic [14:0] ey;
  logic [23:0] v;

  logic [15:0] x1_r;
  logic [23:0] e365_1_r;
  logic [2:0]  q1_r;
  logic [9:0]  dm1_r;

  logic [30:0] p11_2_r;
  logic [22:0] ofs2_r;
  logic [23:0] e365_2_r;
  logic [9:0]  dm2_r;

  logic [23:0] jdn_r;

  // cycle index from the year, then year within the 2820-year cycle
  always_comb begin
    if (year < 14'd474) begin
      qidx = 3'd0;
      ey   = 15'(year) + 15'd2820;
    end else if (year < 14'd3294) begin
      qidx = 3'd1;
      ey   = 15'(year);
    end else if (year < 14'd6114) begin
      qidx = 3'd2;
      ey   = 15'(year) - 15'd2820;
    end else if (year < 14'd8934) begin
      qidx = 3'd3;
      ey   = 15'(year) - 15'd5640;
    end else begin
      qidx = 3'd4;
      ey   = 15'(year) - 15'd8460;
    end
    v = 24'(ey) * 24'd682 - 24'd110;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r     <= 16'(v >> 8);
      e365_1_r <= 24'(ey - 15'd1) * 24'd365;
      q1_r     <= qidx;
      dm1_r    <= 10'(mdays) + 10'(day);
    end
    if (en[1]) begin
      p11_2_r  <= 31'(x1_r) * 31'(M11);
      ofs2_r   <= pers_cyc_ofs(q1_r);
      e365_2_r <= e365_1_r;
      dm2_r    <= dm1_r;
    end
    if (en[2]) begin
      jdn_r <= 24'(p11_2_r >> K11) + e365_2_r + 24'(ofs2_r) + 24'(dm2_r);
    end
  end

  assign jdn = jdn_r;

endmodule

@@ hw/rtl/cdc_d2j.sv @@
// Front end: input checks and date to day number for both calendars, four stages.
// Depends on cdc_pkg and cdc_p2j.
module cdc_d2j
  import cdc_pkg::*;
(
  input  logic     clk,
  input  logic [3:0] en,
  input  in_word_t in_word,
  output side_t    front
);

  logic        m_le2;
  logic [14:0] ya;
  logic [14:0] yb;
  logic        date_in;
  logic        jdn_in;
  logic        err0;

  logic [2:0]  mode1_r, mode2_r, mode3_r;
  logic [22:0] jin1_r, jin2_r, jin3_r;
  logic        err1_r, err2_r, err3_r;
  logic [24:0] t1_1_r;
  logic [29:0] p100_1_r;
  logic [8:0]  t2_1_r;
  logic [4:0]  day1_r;
  logic [25:0] g2_r, g3_r;

  logic [8:0]  c100;
  logic [10:0] t3;
  logic [23:0] pj;
  side_t       front_nxt;
  side_t       front_r;

  cdc_p2j u_p2j (
    .clk   (clk),
    .en    (en[2:0]),
    .year  (in_word.year_in),
    .mdays (pers_mdays(in_word.month_in)),
    .day   (in_word.day_in),
    .jdn   (pj)
  );

  always_comb begin
    m_le2   = in_word.month_in <= 4'd2;
    ya      = 15'(in_word.year_in) + (m_le2 ? 15'd4799 : 15'd4800);
    yb      = 15'(in_word.year_in) + (m_le2 ? 15'd4899 : 15'd4900);
    date_in = in_word.mode == MODE_G2J || in_word.mode == MODE_P2J ||
              in_word.mode == MODE_G2P || in_word.mode == MODE_P2G;
    jdn_in  = in_word.mode == MODE_J2G || in_word.mode == MODE_J2P;
    err0    = in_word.mode > MODE_P2G;
    if (date_in && (in_word.year_in == 14'd0 || 15'(in_word.year_in) > YEAR_MAX ||
                    in_word.month_in == 4'd0 || in_word.month_in > 4'd12 ||
                    in_word.day_in == 5'd0)) begin
      err0 = 1'b1;
    end
    if (jdn_in && (in_word.day_number_in < JDN_LOW || in_word.day_number_in > JDN_HIGH)) begin
      err0 = 1'b1;
    end
  end

  always_comb begin
    c100 = 9'(p100_1_r >> K100);
    t3   = 11'((12'(c100) * 12'd3) >> 2);
  end

  always_comb begin
    front_nxt.mode = mode3_r;
    front_nxt.err  = err3_r;
    front_nxt.jdn  = jin3_r;
    case (mode3_r)
      MODE_G2J: begin
        front_nxt.jdn = g3_r[22:0];
        if (g3_r > 26'(JDN_HIGH)) front_nxt.err = 1'b1;
      end
      MODE_G2P: begin
        front_nxt.jdn = g3_r[22:0];
      end
      MODE_P2J: begin
        front_nxt.jdn = pj[22:0];
        if (pj > 24'(JDN_HIGH)) front_nxt.err = 1'b1;
      end
      MODE_P2G: begin
        front_nxt.jdn = pj[22:0];
        if (pj < 24'(JDN_LOW) || pj > 24'(JDN_HIGH)) front_nxt.err = 1'b1;
      end
      default: begin
        front_nxt.jdn = jin3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode1_r  <= in_word.mode;
      jin1_r   <= in_word.day_number_in;
      err1_r   <= err0;
      t1_1_r   <= 25'((27'(ya) * 27'd1461) >> 2);
      p100_1_r <= 30'(yb) * 30'(M100);
      t2_1_r   <= greg_mterm(in_word.month_in);
      day1_r   <= in_word.day_in;
    end
    if (en[1]) begin
      mode2_r <= mode1_r;
      jin2_r  <= jin1_r;
      err2_r  <= err1_r;
      g2_r    <= 26'(t1_1_r) + 26'(t2_1_r) + 26'(day1_r) - 26'(t3) - GREG_OFS;
    end
    if (en[2]) begin
      mode3_r <= mode2_r;
      jin3_r  <= jin2_r;
      err3_r  <= err2_r;
      g3_r    <= g2_r;
    end
    if (en[3]) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

@@ hw/rtl/cdc_j2g.sv @@
// Day number to Gregorian date, ten register stages.
// Depends on cdc_pkg.
module cdc_j2g
  import cdc_pkg::*;
(
  input  logic        clk,
  input  logic [9:0]  en,
  input  logic [22:0] jdn,
  output logic [14:0] year,
  output logic [3:0]  month,
  output logic [9:0]  day
);

  logic [22:0] l;
  logic [7:0]  n;
  logic [6:0]  i;
  logic [16:0] x80;
  logic [3:0]  j;

  logic [22:0] l1_r;
  logic [50:0] pn1_r;
  logic [7:0]  n2_r, n3_r, n4_r, n5_r, n6_r, n7_r, n8_r, n9_r;
  logic [15:0] l2_2_r, l2_3_r, l2_4_r;
  logic [27:0] xi3_r;
  logic [56:0] pi4_r;
  logic [6:0]  i5_r, i6_r, i7_r, i8_r, i9_r;
  logic [9:0]  l3_5_r, l3_6_r, l3_7_r, l3_8_r;
  logic [33:0] pj6_r;
  logic [3:0]  j7_r, j8_r, j9_r;
  logic [14:0] t7_r;
  logic [30:0] pd8_r;
  logic [9:0]  d9_r;
  logic        l4_9_r;
  logic [14:0] year_r;
  logic [3:0]  month_r;
  logic [9:0]  day_r;

  always_comb begin
    l   = jdn + GJ_OFS;
    n   = 8'(pn1_r >> KN);
    i   = 7'(pi4_r >> KI);
    x80 = 17'(l3_5_r) * 17'd80;
    j   = 4'(pj6_r >> KJ);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l1_r  <= l;
      pn1_r <= 51'({l, 2'b00}) * 51'(MN);
    end
    if (en[1]) begin
      n2_r   <= n;
      l2_2_r <= 16'(25'(l1_r) - 25'((26'(n) * 26'd146097 + 26'd3) >> 2));
    end
    if (en[2]) begin
      n3_r   <= n2_r;
      l2_3_r <= l2_2_r;
      xi3_r  <= 28'((29'(l2_2_r) + 29'd1) * 29'd4000);
    end
    if (en[3]) begin
      n4_r   <= n3_r;
      l2_4_r <= l2_3_r;
      pi4_r  <= 57'(xi3_r) * 57'(MI);
    end
    if (en[4]) begin
      n5_r   <= n4_r;
      i5_r   <= i;
      l3_5_r <= 10'(17'(l2_4_r) + 17'd31 - 17'((18'(i) * 18'd1461) >> 2));
    end
    if (en[5]) begin
      n6_r   <= n5_r;
      i6_r   <= i5_r;
      l3_6_r <= l3_5_r;
      pj6_r  <= 34'(x80) * 34'(MJ);
    end
    if (en[6]) begin
      n7_r   <= n6_r;
      i7_r   <= i6_r;
      l3_7_r <= l3_6_r;
      j7_r   <= j;
      t7_r   <= 15'(j) * 15'd2447;
    end
    if (en[7]) begin
      n8_r   <= n7_r;
      i8_r   <= i7_r;
      l3_8_r <= l3_7_r;
      j8_r   <= j7_r;
      pd8_r  <= 31'(t7_r) * 31'(M80);
    end
    if (en[8]) begin
      n9_r   <= n8_r;
      i9_r   <= i8_r;
      j9_r   <= j8_r;
      d9_r   <= l3_8_r - 10'(pd8_r >> K80);
      l4_9_r <= j8_r >= 4'd11;
    end
    if (en[9]) begin
      month_r <= j9_r + 4'd2 - (l4_9_r ? 4'd12 : 4'd0);
      year_r  <= (15'(n9_r) - 15'd49) * 15'd100 + 15'(i9_r) + 15'(l4_9_r);
      day_r   <= d9_r;
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign day   = day_r;

endmodule

@@ hw/rtl/cdc_j2p.sv @@
// Day number to Persian date, ten register stages; uses cdc_p2j for the year start.
// Depends on cdc_pkg and cdc_p2j.
module cdc_j2p
  import cdc_pkg::*;
(
  input  logic        clk,
  input  logic [9:0]  en,
  input  logic [22:0] jdn,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [8:0]  day,
  output logic        ok
);

  localparam logic [8:0] MON_START [12] = '{9'd32, 9'd63, 9'd94, 9'd125, 9'd156, 9'd187,
                                            9'd217, 9'd247, 9'd277, 9'd307, 9'd337, 9'd367};

  logic signed [24:0] dep;
  logic signed [24:0] cyw;
  logic signed [2:0]  cyc;
  logic [11:0]        a1;
  logic [2:0]         kq;
  logic [11:0]        yc;
  logic signed [15:0] yoff;
  logic signed [15:0] yr;
  logic [3:0]         cnt;
  logic [23:0]        pj;

  logic [19:0]        cy1_r, cy2_r;
  logic signed [2:0]  cyc1_r, cyc2_r, cyc3_r, cyc4_r;
  logic [22:0]        jdn1_r, jdn2_r, jdn3_r, jdn4_r, jdn5_r, jdn6_r, jdn7_r, jdn8_r;
  logic [38:0]        pa2_r;
  logic [11:0]        a1_3_r, a1_4_r;
  logic [8:0]         a2_3_r;
  logic               last3_r, last4_r;
  logic [22:0]        num4_r;
  logic [13:0]        yr5_r, yr6_r, yr7_r, yr8_r, yr9_r;
  logic               ok5_r, ok6_r, ok7_r, ok8_r, ok9_r;
  logic [8:0]         yday9_r;
  logic [13:0]        year_r;
  logic [3:0]         month_r;
  logic [8:0]         day_r;
  logic               ok_r;

  // which 2820-year cycle, counted from year 475
  always_comb begin
    dep = $signed({2'b00, jdn}) - $signed({2'b00, PERS_JDN_475});
    if (dep < 0) begin
      cyc = -3'sd1;
      cyw = dep + $signed({5'd0, CYCLE_DAYS});
    end else if (dep < $signed({5'd0, CYCLE_DAYS})) begin
      cyc = 3'sd0;
      cyw = dep;
    end else if (dep < 25'sd2059966) begin
      cyc = 3'sd1;
      cyw = dep - $signed({5'd0, CYCLE_DAYS});
    end else if (dep < 25'sd3089949) begin
      cyc = 3'sd2;
      cyw = dep - 25'sd2059966;
    end else begin
      cyc = 3'sd3;
      cyw = dep - 25'sd3089949;
    end
  end

  always_comb begin
    a1 = 12'(pa2_r >> K183);
    kq = '0;
    for (int k = 1; k <= 6; k++) begin
      if (num4_r >= 23'(k * CYCLE_YDIV)) kq = kq + 3'd1;
    end
    yc = last4_r ? CYCLE_YEARS : a1_4_r + 12'd1 + 12'(kq);
    case (cyc4_r)
      -3'sd1:  yoff = -16'sd2346;
      3'sd0:   yoff = 16'sd474;
      3'sd1:   yoff = 16'sd3294;
      3'sd2:   yoff = 16'sd6114;
      default: yoff = 16'sd8934;
    endcase
    yr = $signed({4'd0, yc}) + yoff;
  end

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 12; k++) begin
      if (yday9_r >= MON_START[k]) cnt = cnt + 4'd1;
    end
  end

  cdc_p2j u_p2j (
    .clk   (clk),
    .en    (en[7:5]),
    .year  (yr5_r),
    .mdays (9'd0),
    .day   (5'd1),
    .jdn   (pj)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cy1_r  <= cyw[19:0];
      cyc1_r <= cyc;
      jdn1_r <= jdn;
    end
    if (en[1]) begin
      cy2_r  <= cy1_r;
      cyc2_r <= cyc1_r;
      jdn2_r <= jdn1_r;
      pa2_r  <= 39'(cy1_r >> 1) * 39'(M183);
    end
    if (en[2]) begin
      a1_3_r  <= a1;
      a2_3_r  <= 9'(cy2_r - 20'(21'(a1) * 21'd366));
      last3_r <= cy2_r == CYCLE_DAYS - 20'd1;
      cyc3_r  <= cyc2_r;
      jdn3_r  <= jdn2_r;
    end
    if (en[3]) begin
      num4_r  <= 23'(a1_3_r) * 23'd2134 + 23'(a2_3_r) * 23'd2816 + 23'd2815;
      a1_4_r  <= a1_3_r;
      last4_r <= last3_r;
      cyc4_r  <= cyc3_r;
      jdn4_r  <= jdn3_r;
    end
    if (en[4]) begin
      yr5_r  <= yr[13:0];
      ok5_r  <= yr >= 16'sd1 && yr <= 16'sd9999;
      jdn5_r <= jdn4_r;
    end
    if (en[5]) begin
      yr6_r  <= yr5_r;
      ok6_r  <= ok5_r;
      jdn6_r <= jdn5_r;
    end
    if (en[6]) begin
      yr7_r  <= yr6_r;
      ok7_r  <= ok6_r;
      jdn7_r <= jdn6_r;
    end
    if (en[7]) begin
      yr8_r  <= yr7_r;
      ok8_r  <= ok7_r;
      jdn8_r <= jdn7_r;
    end
    if (en[8]) begin
      yday9_r <= 9'(24'(jdn8_r) - pj + 24'd1);
      yr9_r   <= yr8_r;
      ok9_r   <= ok8_r;
    end
    if (en[9]) begin
      year_r  <= yr9_r;
      month_r <= cnt + 4'd1;
      day_r   <= yday9_r - pers_mdays(cnt + 4'd1);
      ok_r    <= ok9_r;
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign day   = day_r;
  assign ok    = ok_r;

endmodule

@@ hw/rtl/calendar_date_converter.sv @@
// Top level of the calendar date converter: stage valid bits, flow control,
// side pipe and output word. Depends on cdc_pkg, cdc_d2j, cdc_j2g, cdc_j2p.
//
//   port group         dir   payload      handshake
//   in_valid/in_stall  in    in_word_t    word taken when in_valid && !in_stall
//   out_valid/out_stall out  out_word_t   word taken when out_valid && !out_stall
//
// One word per cycle sustained while out_stall stays low; each word passes through
// 4 front stages, 10 conversion stages and 1 output register.
// Both conversion pipes run on every word; the output stage picks by mode.
// Every stage has its own valid bit and loads when empty or when the next stage
// moves, so bubbles close up behind a stalled output.
// rst_n clears only the valid bits.
module calendar_date_converter
  import cdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES-1:0] v_nxt;
  logic [N_STAGES-1:0] adv;

  side_t     front;
  side_t     sd_r [CONV_STAGES];
  side_t     sd_last;
  logic [14:0] gy;
  logic [3:0]  gm;
  logic [9:0]  gd;
  logic [13:0] py;
  logic [3:0]  pm;
  logic [8:0]  pd;
  logic        pok;
  logic        err_f;
  out_word_t   out_nxt;
  out_word_t   out_r;

  always_comb begin
    adv[N_STAGES-1] = !v_r[N_STAGES-1] || !out_stall;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  cdc_d2j u_d2j (
    .clk     (clk),
    .en      (adv[FRONT_STAGES-1:0]),
    .in_word (in_word),
    .front   (front)
  );

  cdc_j2g u_j2g (
    .clk   (clk),
    .en    (adv[FRONT_STAGES+CONV_STAGES-1:FRONT_STAGES]),
    .jdn   (front.jdn),
    .year  (gy),
    .month (gm),
    .day   (gd)
  );

  cdc_j2p u_j2p (
    .clk   (clk),
    .en    (adv[FRONT_STAGES+CONV_STAGES-1:FRONT_STAGES]),
    .jdn   (front.jdn),
    .year  (py),
    .month (pm),
    .day   (pd),
    .ok    (pok)
  );

  always_ff @(posedge clk) begin
    if (adv[FRONT_STAGES]) sd_r[0] <= front;
    for (int k = 1; k < CONV_STAGES; k++) begin
      if (adv[FRONT_STAGES+k]) sd_r[k] <= sd_r[k-1];
    end
  end

  assign sd_last = sd_r[CONV_STAGES-1];

  always_comb begin
    err_f   = sd_last.err;
    out_nxt = '0;
    case (sd_last.mode)
      MODE_G2J, MODE_P2J: begin
        out_nxt.day_number_out = sd_last.jdn;
      end
      MODE_J2G, MODE_P2G: begin
        if (gy == 15'd0 || gy > YEAR_MAX || gm > 4'd12 || gd > 10'd31) err_f = 1'b1;
        out_nxt.year_out  = gy[13:0];
        out_nxt.month_out = gm;
        out_nxt.day_out   = gd[4:0];
      end
      MODE_J2P, MODE_G2P: begin
        if (!pok || pm > 4'd12 || pd > 9'd31) err_f = 1'b1;
        out_nxt.year_out  = py;
        out_nxt.month_out = pm;
        out_nxt.day_out   = pd[4:0];
      end
      default: begin
        err_f = 1'b1;
      end
    endcase
    if (err_f) begin
      out_nxt             = '0;
      out_nxt.range_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[N_STAGES-1]) out_r <= out_nxt;
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[N_STAGES-1];
  assign out_word  = out_r;

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[0])
    else $error("input stalled with an empty first stage");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("valid bits not cleared by reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.range_error |->
      out_word.day_number_out == '0 && out_word.year_out == '0 &&
      out_word.month_out == '0 && out_word.day_out == '0)
    else $error("range error word with nonzero fields");

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.range_error && out_word.year_out != '0 |->
      out_word.month_out >= 4'd1 && out_word.month_out <= 4'd12 &&
      out_word.day_out != '0 && out_word.day_number_out == '0)
    else $error("date result out of shape");

  a_jdn_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.range_error && out_word.day_number_out != '0 |->
      out_word.year_out == '0 && out_word.month_out == '0)
    else $error("day number result carries a date");
`endif

endmodule

@@ test/tb_top.sv @@
// Testbench for calendar_date_converter: a directed table, then random words under
// several idle/stall phases, each result checked against a table value or a date-conversion predictor.
// Depends on cdc_pkg and the RTL of the converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cdc_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam longint DAY_LO = 1721426;
  localparam longint DAY_HI = 5373484;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  calendar_date_converter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #1 clk = ~clk;

  typedef struct {
    in_word_t  w;
    bit        known;
    out_word_t res;
  } dir_row_t;

  out_word_t pending_dates[$];
  dir_row_t  dir_rows[$];
  int        err_count = 0;
  int        cycles = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint fmod(longint a, longint b);
    longint r;
    r = a % b;
    if (r < 0) r += b;
    return r;
  endfunction

  function automatic longint greg_day_number(longint y, longint m, longint d);
    longint a;
    a = (m - 14) / 12;
    return (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
         - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
  endfunction

  function automatic void day_number_to_greg(input longint jd, output longint y,
                                             output longint m, output longint d);
    longint l, n, i, j;
    l = jd + 68569;
    n = (4 * l) / 146097;
    l = l - (146097 * n + 3) / 4;
    i = (4000 * (l + 1)) / 1461001;
    l = l - (1461 * i) / 4 + 31;
    j = (80 * l) / 2447;
    d = l - (2447 * j) / 80;
    l = j / 11;
    m = j + 2 - 12 * l;
    y = 100 * (n - 49) + i + l;
  endfunction

  function automatic longint pers_day_number(longint y, longint m, longint d);
    longint base, ey, md;
    base = y - 474;
    ey = 474 + fmod(base, 2820);
    md = (m <= 7) ? (m - 1) * 31 : (m - 1) * 30 + 6;
    return d + md + fdiv(ey * 682 - 110, 2816) + (ey - 1) * 365
         + fdiv(base, 2820) * 1029983 + 1948320;
  endfunction

  // ok is cleared when the Persian year leaves 1..9999
  function automatic void day_number_to_pers(input longint jd, output bit ok,
                                             output longint y, output longint m,
                                             output longint d);
    longint dep, cyc, cy, yc, yr, yday, a1, a2;
    dep = jd - pers_day_number(475, 1, 1);
    cyc = fdiv(dep, 1029983);
    cy = fmod(dep, 1029983);
    if (cy == 1029982) yc = 2820;
    else begin
      a1 = cy / 366;
      a2 = cy % 366;
      yc = (2134 * a1 + 2816 * a2 + 2815) / 1028522 + a1 + 1;
    end
    yr = yc + 2820 * cyc + 474;
    ok = (yr >= 1 && yr <= 9999);
    y = 0; m = 0; d = 0;
    if (ok) begin
      yday = jd - pers_day_number(yr, 1, 1) + 1;
      if (yday <= 186) m = fdiv(yday - 1, 31) + 1;
      else m = fdiv(yday - 7, 30) + 1;
      y = yr;
      d = jd - pers_day_number(yr, m, 1) + 1;
    end
  endfunction

  function automatic out_word_t predict_date(in_word_t w);
    out_word_t r;
    longint jin, yin, min_, din, jo, yo, mo, dd, t;
    bit err, ok, date_mode, day_mode;
    jin = w.day_number_in; yin = w.year_in; min_ = w.month_in; din = w.day_in;
    jo = 0; yo = 0; mo = 0; dd = 0; err = 0; ok = 1;
    date_mode = w.mode inside {MODE_G2J, MODE_P2J, MODE_G2P, MODE_P2G};
    day_mode = w.mode inside {MODE_J2G, MODE_J2P};
    if (w.mode > MODE_P2G) err = 1;
    if (date_mode && (yin < 1 || yin > 9999 || min_ < 1 || min_ > 12 || din < 1 || din > 31))
      err = 1;
    if (day_mode && (jin < DAY_LO || jin > DAY_HI)) err = 1;
    if (!err) begin
      case (w.mode)
        MODE_G2J: begin
          jo = greg_day_number(yin, min_, din);
          if (jo < 0 || jo > DAY_HI) err = 1;
        end
        MODE_J2G: day_number_to_greg(jin, yo, mo, dd);
        MODE_P2J: begin
          jo = pers_day_number(yin, min_, din);
          if (jo < 0 || jo > DAY_HI) err = 1;
        end
        MODE_J2P: begin
          day_number_to_pers(jin, ok, yo, mo, dd);
          err = !ok;
        end
        MODE_G2P: begin
          day_number_to_pers(greg_day_number(yin, min_, din), ok, yo, mo, dd);
          err = !ok;
        end
        default: begin
          t = pers_day_number(yin, min_, din);
          if (t < DAY_LO || t > DAY_HI) err = 1;
          else day_number_to_greg(t, yo, mo, dd);
        end
      endcase
    end
    if (!err && w.mode inside {MODE_J2G, MODE_J2P, MODE_G2P, MODE_P2G} &&
        (yo < 1 || yo > 9999 || mo < 0 || mo > 12 || dd < 0 || dd > 31))
      err = 1;
    r = '0;
    if (err) r.range_error = 1'b1;
    else begin
      r.day_number_out = jo[22:0];
      r.year_out = yo[13:0];
      r.month_out = mo[3:0];
      r.day_out = dd[4:0];
    end
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("pending words", 0, 1);
      end else begin
        e = pending_dates.pop_front();
        if (out_word.day_number_out !== e.day_number_out)
          report_mismatch("day_number_out", e.day_number_out, out_word.day_number_out);
        if (out_word.year_out !== e.year_out)
          report_mismatch("year_out", e.year_out, out_word.year_out);
        if (out_word.month_out !== e.month_out)
          report_mismatch("month_out", e.month_out, out_word.month_out);
        if (out_word.day_out !== e.day_out)
          report_mismatch("day_out", e.day_out, out_word.day_out);
        if (out_word.range_error !== e.range_error)
          report_mismatch("range_error", e.range_error, out_word.range_error);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver side: long hold-offs counted here, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else
      out_stall = ($urandom_range(99, 0) < stall_pct);
  end

  // ---------------- stimulus ----------------
  task automatic send_word(in_word_t w, out_word_t want);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid = 1'b0;
      in_word = in_word_t'(49'({$urandom(), $urandom()}));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(want);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_word_t mk_word(logic [2:0] m, longint jd, longint y,
                                       longint mo, longint d);
    in_word_t w;
    w.mode = m;
    w.day_number_in = jd[22:0];
    w.year_in = y[13:0];
    w.month_in = mo[3:0];
    w.day_in = d[4:0];
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    logic [2:0] m;
    if ($urandom_range(9, 0) == 0) begin
      w = in_word_t'(49'({$urandom(), $urandom()}));
      return w;
    end
    m = 3'($urandom_range(5, 0));
    w = mk_word(m, longint'($urandom_range(DAY_HI, DAY_LO)),
                longint'($urandom_range(9999, 1)),
                longint'($urandom_range(12, 1)), longint'($urandom_range(31, 1)));
    // Persian years beyond about 9378 overflow the day-number range; keep most in range
    if ((m == MODE_P2J || m == MODE_P2G) && $urandom_range(3, 0) != 0)
      w.year_in = 14'($urandom_range(7000, 1));
    if (m == MODE_G2P && $urandom_range(3, 0) != 0)
      w.year_in = 14'($urandom_range(9999, 700));
    if ($urandom_range(19, 0) == 0)
      w.day_number_in = 23'($urandom_range(1, 0) ? DAY_LO + $urandom_range(3, 0)
                                                 : DAY_HI - $urandom_range(3, 0));
    return w;
  endfunction

  task automatic add_row(in_word_t w, bit known, out_word_t res);
    dir_row_t r;
    r.w = w; r.known = known; r.res = res;
    dir_rows.push_back(r);
  endtask

  initial begin
    out_word_t bad, r;
    in_word_t w;
    int phase;
    bad = '0;
    bad.range_error = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    r = '0; r.day_number_out = 23'd2451545;
    add_row(mk_word(MODE_G2J, 0, 2000, 1, 1), 1, r);
    r = '0; r.day_number_out = 23'd1948321;
    add_row(mk_word(MODE_P2J, 0, 1, 1, 1), 1, r);
    add_row(mk_word(MODE_SPARE6, DAY_LO, 2000, 1, 1), 1, bad);
    add_row(mk_word(MODE_SPARE7, DAY_LO, 2000, 1, 1), 1, bad);
    add_row(mk_word(MODE_G2J, 0, 0, 1, 1), 1, bad);
    add_row(mk_word(MODE_G2J, 0, 10000, 1, 1), 1, bad);
    add_row(mk_word(MODE_P2G, 0, 16383, 15, 31), 1, bad);
    add_row(mk_word(MODE_G2P, 0, 2000, 13, 1), 1, bad);
    add_row(mk_word(MODE_P2J, 0, 1400, 0, 1), 1, bad);
    add_row(mk_word(MODE_G2J, 0, 2000, 1, 0), 1, bad);
    add_row(mk_word(MODE_J2G, DAY_LO - 1, 0, 0, 0), 1, bad);
    add_row(mk_word(MODE_J2P, DAY_HI + 1, 0, 0, 0), 1, bad);
    add_row(mk_word(MODE_J2G, 0, 0, 0, 0), 1, bad);
    // the rest come from the predictor
    add_row(mk_word(MODE_J2G, DAY_LO, 0, 0, 0), 0, bad);
    add_row(mk_word(MODE_J2G, DAY_HI, 0, 0, 0), 0, bad);
    add_row(mk_word(MODE_J2P, DAY_LO, 0, 0, 0), 0, bad);
    add_row(mk_word(MODE_J2P, DAY_HI, 0, 0, 0), 0, bad);
    add_row(mk_word(MODE_G2J, 0, 9999, 12, 31), 0, bad);
    add_row(mk_word(MODE_G2J, 0, 1, 1, 1), 0, bad);
    add_row(mk_word(MODE_G2P, 0, 1, 1, 1), 0, bad);          // Persian year before 1
    add_row(mk_word(MODE_G2P, 0, 2024, 2, 31), 0, bad);      // day past end of month
    add_row(mk_word(MODE_P2J, 0, 9999, 12, 31), 0, bad);     // result above day range
    add_row(mk_word(MODE_P2G, 0, 100, 7, 31), 0, bad);       // year before 475, negative cycle
    add_row(mk_word(MODE_P2G, 0, 1403, 12, 30), 0, bad);
    add_row(mk_word(MODE_J2P, 23'd2121445, 0, 0, 0), 0, bad);

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].known ? dir_rows[i].res : predict_date(dir_rows[i].w));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      if (phase == 1) hold_cycles = 300;   // fill the pipe while the sender keeps going
      for (int n = 0; n < 300; n++) begin
        if (phase == 3 && n == 150) begin
          in_valid = 1'b0;
          wait (pending_dates.size() == 0);
          @(negedge clk);
        end
        w = rand_word();
        send_word(w, predict_date(w));
      end
    end
    idle_pct = 0;
    stall_pct = 0;

    wait (pending_dates.size() == 0);
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
